// ----- rtl/core/rpce_pkg.sv -----
`timescale 1ns / 1ps
package rpce_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = 5;
	localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
	localparam logic [31:0] Q30_GAIN = 32'h26DD3B6A;

	localparam logic [2:0] REQ_IDENT = 3'd0;
	localparam logic [2:0] REQ_TRANS = 3'd1;
	localparam logic [2:0] REQ_ROTX  = 3'd2;
	localparam logic [2:0] REQ_ROTY  = 3'd3;
	localparam logic [2:0] REQ_ROTZ  = 3'd4;
	localparam logic [2:0] REQ_POINT = 3'd5;
	localparam logic [2:0] REQ_INV   = 3'd6;
	// unused code, pose left as it is
	localparam logic [2:0] REQ_SPARE = 3'd7;

	// arctangent steps, 2^32 units per turn
	function automatic logic [31:0] atan_step(input logic [STEP_W-1:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sh07FFFFFFF) r = 32'sh7FFFFFFF;
		else if (v < -36'sh080000000) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/core/rpce_cordic.sv -----
`timescale 1ns / 1ps
// one rotation step per cycle, results in FRAC_BITS
module rpce_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [15:0] angle,
	output logic done,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);
	localparam int SH = 30 - rpce_pkg::FRAC_BITS;

	logic signed [33:0] x_q, y_q, z_q;
	logic [rpce_pkg::STEP_W-1:0] i_q;
	logic busy_q, flip_q;
	logic [31:0] turn;
	logic flip;
	logic signed [33:0] xs, ys, xr, yr, at;

	assign turn = 32'(angle[rpce_pkg::ANGLE_BITS-1:0]) << (32 - rpce_pkg::ANGLE_BITS);
	assign flip = turn[31] ^ turn[30];
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = 34'(rpce_pkg::atan_step(i_q));
	assign xr = (x_q + (34'sd1 <<< (SH - 1))) >>> SH;
	assign yr = (y_q + (34'sd1 <<< (SH - 1))) >>> SH;
	assign cos_val = rpce_pkg::sat32(36'(flip_q ? -xr : xr));
	assign sin_val = rpce_pkg::sat32(36'(flip_q ? -yr : yr));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == rpce_pkg::STEP_W'(rpce_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			flip_q <= flip;
			x_q    <= 34'(rpce_pkg::Q30_GAIN);
			y_q    <= '0;
			z_q    <= 34'($signed(flip ? turn - 32'h80000000 : turn));
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end
endmodule

// ----- rtl/core/rigid_pose_chain_engine.sv -----
`timescale 1ns / 1ps
// pose engine: keeps a rigid 3x4 pose in q16.16 and applies one request per
// transfer (identity, translate, rotate about x/y/z, transform point, invert).
// one item at a time: stall stays high until the result has been taken.
// a shared 32x32 multiplier does one rounded product per cycle. identity and the
// unused code go straight to the result copy; translate, point and invert take
// 9 products (invert writes each transposed row alongside its origin term), and
// a rotate runs 16 cordic steps, latches sine and cosine, then takes 12 products.
// after the result transfer the block goes idle and can take the next item.
// out_* holds until its transfer completes.
module rigid_pose_chain_engine (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [2:0] req_type,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic [15:0] angle,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CORD = 5'b00010,
		ST_MAC  = 5'b00100,
		ST_COPY = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;
	logic signed [31:0] pose_q [12];
	logic signed [31:0] old_q [12];
	logic signed [31:0] p_q [3];
	logic signed [31:0] res_q [3];
	logic signed [31:0] c_q, s_q;
	logic [2:0] req_q;
	logic [1:0] row_q, term_q;
	logic signed [35:0] acc_q;
	logic cord_start, cord_done;
	logic signed [31:0] cos_w, sin_w;
	logic [1:0] ca, cb;

	// cordic samples the angle at the input transfer
	rpce_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start), .angle(angle),
		.done(cord_done), .cos_val(cos_w), .sin_val(sin_w)
	);

	// rotated column pair
	always_comb begin
		unique case (req_q)
			rpce_pkg::REQ_ROTX: begin ca = 2'd1; cb = 2'd2; end
			rpce_pkg::REQ_ROTY: begin ca = 2'd2; cb = 2'd0; end
			default:            begin ca = 2'd0; cb = 2'd1; end
		endcase
	end

	// operand select for the shared multiplier
	logic signed [31:0] ma, mb;
	logic rot;
	assign rot = (req_q == rpce_pkg::REQ_ROTX) || (req_q == rpce_pkg::REQ_ROTY)
		|| (req_q == rpce_pkg::REQ_ROTZ);
	always_comb begin
		ma = '0;
		mb = '0;
		if (rot) begin
			// terms: c*va, s*vb, c*vb, s*va
			ma = term_q[0] ? s_q : c_q;
			mb = (term_q[0] ^ term_q[1]) ? old_q[{row_q, cb}] : old_q[{row_q, ca}];
		end else if (req_q == rpce_pkg::REQ_INV) begin
			ma = old_q[{term_q, row_q}];
			mb = old_q[{term_q, 2'd3}];
		end else begin
			ma = old_q[{row_q, term_q}];
			mb = p_q[term_q];
		end
	end

	logic signed [63:0] prod;
	logic signed [63:0] prnd;
	logic signed [31:0] pq;
	assign prod = ma * mb;
	assign prnd = (prod + (64'sd1 <<< (rpce_pkg::FRAC_BITS - 1))) >>> rpce_pkg::FRAC_BITS;
	always_comb begin
		if (prnd > 64'sh7FFFFFFF) pq = 32'sh7FFFFFFF;
		else if (prnd < -64'sh80000000) pq = 32'sh80000000;
		else pq = prnd[31:0];
	end

	logic signed [35:0] acc_n;
	logic last_term;
	assign last_term = rot ? (term_q[0]) : (term_q == 2'd2);
	always_comb begin
		if (rot && term_q[1] && term_q[0]) acc_n = acc_q - 36'(pq);
		else acc_n = acc_q + 36'(pq);
	end

	assign cord_start = (state_q == ST_IDLE) && in_valid && (req_type == rpce_pkg::REQ_ROTX
		|| req_type == rpce_pkg::REQ_ROTY || req_type == rpce_pkg::REQ_ROTZ);
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_x = res_q[0];
	assign out_y = res_q[1];
	assign out_z = res_q[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int k = 0; k < 12; k++)
				pose_q[k] <= (k % 5 == 0 && k < 11) ? rpce_pkg::ONE_Q : '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						priority if (req_type == rpce_pkg::REQ_IDENT) begin
							for (int k = 0; k < 12; k++)
								pose_q[k] <= (k % 5 == 0 && k < 11) ? rpce_pkg::ONE_Q : '0;
							state_q <= ST_COPY;
						end else if (cord_start) state_q <= ST_CORD;
						else if (req_type == rpce_pkg::REQ_TRANS
							|| req_type == rpce_pkg::REQ_POINT
							|| req_type == rpce_pkg::REQ_INV) state_q <= ST_MAC;
						else state_q <= ST_COPY;
					end
				end
				ST_CORD: if (cord_done) state_q <= ST_MAC;
				ST_MAC: begin
					if (last_term) begin
						// write back the result of this pass (a whole row for invert)
						if (rot) begin
							if (term_q[1]) pose_q[{row_q, cb}] <= rpce_pkg::sat32(acc_n);
							else pose_q[{row_q, ca}] <= rpce_pkg::sat32(acc_n);
						end else if (req_q == rpce_pkg::REQ_INV) begin
							pose_q[{row_q, 2'd3}] <= rpce_pkg::sat32(-acc_n);
							pose_q[{row_q, 2'd0}] <= old_q[{2'd0, row_q}];
							pose_q[{row_q, 2'd1}] <= old_q[{2'd1, row_q}];
							pose_q[{row_q, 2'd2}] <= old_q[{2'd2, row_q}];
						end else if (req_q == rpce_pkg::REQ_TRANS) begin
							pose_q[{row_q, 2'd3}] <= rpce_pkg::sat32(acc_n);
						end
						if (row_q == 2'd2 && (!rot || term_q[1])) state_q <= ST_COPY;
					end
				end
				ST_COPY: state_q <= ST_OUT;
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_q   <= req_type;
				p_q[0]  <= in_x;
				p_q[1]  <= in_y;
				p_q[2]  <= in_z;
				old_q   <= pose_q;
				row_q   <= '0;
				term_q  <= '0;
				acc_q   <= (req_type == rpce_pkg::REQ_TRANS || req_type == rpce_pkg::REQ_POINT)
					? 36'(pose_q[3]) : '0;
			end
			ST_CORD: begin
				c_q <= cos_w;
				s_q <= sin_w;
			end
			ST_MAC: begin
				if (last_term) begin
					if (req_q == rpce_pkg::REQ_POINT) res_q[row_q] <= rpce_pkg::sat32(acc_n);
					if (rot && !term_q[1]) begin
						term_q <= 2'd2;
						acc_q  <= '0;
					end else begin
						row_q  <= row_q + 1'b1;
						term_q <= '0;
						acc_q  <= (req_q == rpce_pkg::REQ_TRANS || req_q == rpce_pkg::REQ_POINT)
							? 36'(old_q[{row_q + 2'd1, 2'd3}]) : '0;
					end
				end else begin
					term_q <= term_q + 1'b1;
					acc_q  <= acc_n;
				end
			end
			ST_COPY: begin
				if (req_q != rpce_pkg::REQ_POINT) begin
					res_q[0] <= pose_q[3];
					res_q[1] <= pose_q[7];
					res_q[2] <= pose_q[11];
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- rtl/core/rpce_checker.sv -----
`timescale 1ns / 1ps
module rpce_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic signed [31:0] out_x
);
	// no new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");
	// after a transfer in, block goes busy
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall) else $error("not busy after transfer");
	// result holds under stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_x))
		else $error("stalled result changed");
	// ready again after result transfer
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> !in_stall) else $error("not ready after result");
endmodule

bind rigid_pose_chain_engine rpce_checker u_rpce_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_x(out_x)
);

// ----- verif/tb_rigid_pose_chain_engine.sv -----
`timescale 1ns / 1ps
module tb_rigid_pose_chain_engine;

	localparam int  N_ITEMS    = 850;
	localparam longint LIMIT   = 400000;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [15:0]        ang;
	} pose_req_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} vec3_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] req_type;
	logic signed [31:0] in_x, in_y, in_z;
	logic [15:0] angle;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] out_x, out_y, out_z;

	rigid_pose_chain_engine uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .in_x(in_x), .in_y(in_y), .in_z(in_z), .angle(angle),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z)
	);

	// requests waiting for the driver, and results owed by the block
	pose_req_t pending_reqs[$];
	vec3_t     owed_results[$];
	int        err_count = 0;
	int        n_added = 0;
	longint    cycle_count = 0;
	bit        hold_sender;

	// own copy of the pose, row r column c at r*4+c
	longint pose[12];

	// sampled handshake state from the rising edge
	logic in_stall_q;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// rounding fixed-point helpers
	function automatic longint fl_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return clip32(fl_shift(a * b + (64'sd1 <<< (rpce_pkg::FRAC_BITS - 1)),
			rpce_pkg::FRAC_BITS));
	endfunction

	function automatic void pose_identity();
		foreach (pose[i]) pose[i] = 0;
		pose[0] = rpce_pkg::ONE_Q;
		pose[5] = rpce_pkg::ONE_Q;
		pose[10] = rpce_pkg::ONE_Q;
	endfunction

	// cordic sine and cosine of a binary angle
	task automatic trig_of(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] turn;
		logic [31:0] step;
		bit flip;
		longint x, y, z, nx;
		int sh;
		turn = 32'(ang) << (32 - rpce_pkg::ANGLE_BITS);
		flip = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
		if (flip) turn = turn - 32'h80000000;
		z = longint'($signed(turn));
		x = rpce_pkg::Q30_GAIN;
		y = 0;
		for (int i = 0; i < rpce_pkg::CORDIC_STEPS && i < 24; i++) begin
			step = rpce_pkg::atan_step(rpce_pkg::STEP_W'(i));
			if (z >= 0) begin
				nx = x - fl_shift(y, i);
				y = y + fl_shift(x, i);
				z = z - longint'(step);
			end else begin
				nx = x + fl_shift(y, i);
				y = y - fl_shift(x, i);
				z = z + longint'(step);
			end
			x = nx;
		end
		sh = 30 - rpce_pkg::FRAC_BITS;
		x = fl_shift(x + (64'sd1 <<< (sh - 1)), sh);
		y = fl_shift(y + (64'sd1 <<< (sh - 1)), sh);
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clip32(x);
		s = clip32(y);
	endtask

	function automatic vec3_t map_point(longint p0, longint p1, longint p2);
		longint acc[3];
		vec3_t v;
		for (int r = 0; r < 3; r++) begin
			acc[r] = pose[r*4+3] + qmul(pose[r*4], p0) + qmul(pose[r*4+1], p1)
				+ qmul(pose[r*4+2], p2);
			acc[r] = clip32(acc[r]);
		end
		v.vx = 32'(acc[0]);
		v.vy = 32'(acc[1]);
		v.vz = 32'(acc[2]);
		return v;
	endfunction

	// advance the pose by one request and return the result it owes
	task automatic pose_update(input pose_req_t q, output vec3_t res);
		longint c, s, va, vb;
		longint prev[12];
		longint acc;
		vec3_t v;
		int a, b;
		a = 0;
		b = 0;
		case (q.kind)
			rpce_pkg::REQ_IDENT: pose_identity();
			rpce_pkg::REQ_TRANS: begin
				v = map_point(q.px, q.py, q.pz);
				pose[3] = v.vx;
				pose[7] = v.vy;
				pose[11] = v.vz;
			end
			rpce_pkg::REQ_ROTX, rpce_pkg::REQ_ROTY, rpce_pkg::REQ_ROTZ: begin
				trig_of(q.ang, c, s);
				if (q.kind == rpce_pkg::REQ_ROTX) begin
					a = 1; b = 2;
				end else if (q.kind == rpce_pkg::REQ_ROTY) begin
					a = 2; b = 0;
				end else begin
					a = 0; b = 1;
				end
				for (int r = 0; r < 3; r++) begin
					va = pose[r*4+a];
					vb = pose[r*4+b];
					pose[r*4+a] = clip32(qmul(c, va) + qmul(s, vb));
					pose[r*4+b] = clip32(qmul(c, vb) - qmul(s, va));
				end
			end
			rpce_pkg::REQ_INV: begin
				prev = pose;
				for (int r = 0; r < 3; r++) begin
					acc = 0;
					for (int i = 0; i < 3; i++) begin
						pose[r*4+i] = prev[i*4+r];
						acc += qmul(prev[i*4+r], prev[i*4+3]);
					end
					pose[r*4+3] = clip32(-acc);
				end
			end
			default: ;
		endcase
		if (q.kind == rpce_pkg::REQ_POINT) res = map_point(q.px, q.py, q.pz);
		else begin
			res.vx = 32'(pose[3]);
			res.vy = 32'(pose[7]);
			res.vz = 32'(pose[11]);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s at cycle %0d: got %h want %h", what, cycle_count, got, want);
		err_count++;
	endtask

	// random 32-bit value biased toward extremes and small magnitudes
	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2, 3: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
		endcase
	endfunction

	// driver: bursts with random gaps, changes at the falling edge
	int gap_left;
	int burst_left;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= rpce_pkg::REQ_IDENT;
			in_x <= '0;
			in_y <= '0;
			in_z <= '0;
			angle <= '0;
			gap_left <= 0;
			burst_left <= 0;
		end else if (!(in_valid && in_stall_q)) begin
			// nothing offered, or the last item went across at the rising edge
			if (gap_left == 0 && pending_reqs.size() > 0 && !hold_sender) begin
				req_type <= pending_reqs[0].kind;
				in_x <= pending_reqs[0].px;
				in_y <= pending_reqs[0].py;
				in_z <= pending_reqs[0].pz;
				angle <= pending_reqs[0].ang;
				void'(pending_reqs.pop_front());
				in_valid <= 1'b1;
				if (burst_left > 0) burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(0, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end
		end
	end

	always @(posedge clk) in_stall_q <= in_stall;

	// prediction on accepted requests
	always @(posedge clk) begin
		pose_req_t q;
		vec3_t r;
		if (!arst_n) pose_identity();
		else if (in_valid && !in_stall) begin
			q.kind = req_type;
			q.px = in_x;
			q.py = in_y;
			q.pz = in_z;
			q.ang = angle;
			pose_update(q, r);
			owed_results.push_back(r);
		end
	end

	// receiver stall pattern: phases of heavy, light and no stalling
	int stall_mode;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// monitor: compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		vec3_t w;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					report_mismatch("unexpected result out_x", out_x, '0);
				end else begin
					w = owed_results.pop_front();
					if (out_x !== w.vx) report_mismatch("out_x", out_x, w.vx);
					if (out_y !== w.vy) report_mismatch("out_y", out_y, w.vy);
					if (out_z !== w.vz) report_mismatch("out_z", out_z, w.vz);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycle_count > LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic add_req(input logic [2:0] k, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [15:0] a);
		pose_req_t q;
		q.kind = k;
		q.px = x;
		q.py = y;
		q.pz = z;
		q.ang = a;
		pending_reqs.push_back(q);
		n_added++;
	endtask

	// a chain of rigid moves then a probe, an invert half of the time, and a second probe
	task automatic add_chain();
		int n;
		n = $urandom_range(2, 8);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: add_req(rpce_pkg::REQ_TRANS, pick_val(), pick_val(), pick_val(),
					16'($urandom));
				1: add_req(rpce_pkg::REQ_ROTX, $urandom, $urandom, $urandom, 16'($urandom));
				2: add_req(rpce_pkg::REQ_ROTY, $urandom, $urandom, $urandom, 16'($urandom));
				default: add_req(rpce_pkg::REQ_ROTZ, $urandom, $urandom, $urandom,
					16'($urandom));
			endcase
		end
		add_req(rpce_pkg::REQ_POINT, pick_val(), pick_val(), pick_val(), 16'($urandom));
		if ($urandom_range(0, 1)) add_req(rpce_pkg::REQ_INV, $urandom, $urandom, $urandom,
			16'($urandom));
		add_req(rpce_pkg::REQ_POINT, pick_val(), pick_val(), pick_val(), 16'($urandom));
	endtask

	initial begin
		logic [2:0] k;
		arst_n = 1'b0;
		hold_sender = 1'b0;

		// directed: every request, field extremes, quadrant edges of the angle
		add_req(rpce_pkg::REQ_POINT, 32'h00010000, 32'h00020000, 32'h00030000, 16'h0000);
		add_req(rpce_pkg::REQ_TRANS, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 16'hFFFF);
		add_req(rpce_pkg::REQ_TRANS, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 16'h0000);
		add_req(rpce_pkg::REQ_ROTX, 32'h0, 32'h0, 32'h0, 16'h4000);
		add_req(rpce_pkg::REQ_ROTY, 32'h0, 32'h0, 32'h0, 16'h8000);
		add_req(rpce_pkg::REQ_ROTZ, 32'h0, 32'h0, 32'h0, 16'hC000);
		add_req(rpce_pkg::REQ_ROTZ, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		add_req(rpce_pkg::REQ_ROTX, 32'h0, 32'h0, 32'h0, 16'h3FFF);
		add_req(rpce_pkg::REQ_ROTY, 32'h0, 32'h0, 32'h0, 16'hBFFF);
		add_req(rpce_pkg::REQ_POINT, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h0);
		add_req(rpce_pkg::REQ_INV, 32'h0, 32'h0, 32'h0, 16'h0);
		add_req(rpce_pkg::REQ_POINT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0);
		add_req(rpce_pkg::REQ_SPARE, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 16'h5555);
		add_req(rpce_pkg::REQ_IDENT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		add_req(rpce_pkg::REQ_TRANS, 32'h00050000, 32'hFFFB0000, 32'h00008000, 16'h0);
		add_req(rpce_pkg::REQ_ROTZ, 32'h0, 32'h0, 32'h0, 16'h2000);
		add_req(rpce_pkg::REQ_INV, 32'h0, 32'h0, 32'h0, 16'h0);
		add_req(rpce_pkg::REQ_INV, 32'h0, 32'h0, 32'h0, 16'h0);
		add_req(rpce_pkg::REQ_IDENT, 32'h0, 32'h0, 32'h0, 16'h0);

		#1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// let the directed part drain, then hold the sender until all results are in
		while (pending_reqs.size() != 0) @(posedge clk);
		hold_sender = 1'b1;
		while (owed_results.size() != 0 || in_valid) @(posedge clk);
		hold_sender = 1'b0;

		while (n_added < N_ITEMS) begin
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 7) == 0) add_req(rpce_pkg::REQ_IDENT, $urandom,
					$urandom, $urandom, 16'($urandom));
				add_chain();
			end else begin
				k = 3'($urandom_range(0, 7));
				add_req(k, pick_val(), pick_val(), pick_val(), 16'($urandom));
			end
			while (pending_reqs.size() > 20) @(posedge clk);
		end
		while (pending_reqs.size() != 0) @(posedge clk);
		while (owed_results.size() != 0 || in_valid) @(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0 && owed_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
